// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define DSTWR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define DSTWR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dstwr_pkg.sv =====
// Types, codes and reset constants of the ranging responder.
package dstwr_pkg;

	// Default width of the radio timestamps
	localparam int STAMP_BITS_DEF = 40;

	// Configuration register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 2'd1;

	// Register reset values
	localparam logic [7:0]  OWN_ADDR_RST   = 8'd3;
	localparam logic [15:0] TIMEOUT_MS_RST = 16'd10;

	// Radio events
	typedef enum logic [1:0] {
		CMD_POLL    = 2'd0,
		CMD_FRAME   = 2'd1,
		CMD_RX_ERR  = 2'd2,
		CMD_TX_DONE = 2'd3
	} cmd_t;

	// Radio actions
	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_REARM     = 3'd1,
		ACT_SEND_RESP = 3'd2,
		ACT_SEND_ERR  = 3'd3,
		ACT_SEND_INFO = 3'd4,
		ACT_CLR_ERR   = 3'd5
	} action_t;

	// Session stage codes
	localparam logic [1:0] STG_IDLE    = 2'd0;
	localparam logic [1:0] STG_WAIT_TX = 2'd1;
	localparam logic [1:0] STG_WAIT_FN = 2'd2;

	// Ranging stages carried in frames
	localparam logic [2:0] FRAME_REQUEST = 3'd1;
	localparam logic [2:0] FRAME_FINAL   = 3'd3;

	// Session state held between items, minus the timestamps
	typedef struct packed {
		logic [1:0]  stage;
		logic [31:0] reply_interval;
		logic [31:0] last_activity;
	} sess_t;

	// Next-state update from the step logic
	typedef struct packed {
		sess_t sess;
		logic  ld_rx;
		logic  ld_tx;
	} upd_t;

	// One result item
	typedef struct packed {
		action_t            action;
		logic signed [31:0] round_time;
		logic signed [31:0] reply_time;
		logic [1:0]         session_stage;
	} result_t;

endpackage

// ===== rtl/dstwr_if.sv =====
// Valid/ready channels for radio events and responder results.
interface dstwr_evt_if #(
	parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            command;
	logic [31:0]           now_ms;
	logic [7:0]            dest_id;
	logic [2:0]            frame_stage;
	logic                  is_error_frame;
	logic [STAMP_BITS-1:0] rx_stamp;
	logic [STAMP_BITS-1:0] tx_stamp;

	modport source (
		output valid, command, now_ms, dest_id, frame_stage, is_error_frame,
		rx_stamp, tx_stamp,
		input  ready
	);
	modport sink (
		input  valid, command, now_ms, dest_id, frame_stage, is_error_frame,
		rx_stamp, tx_stamp,
		output ready
	);
endinterface

interface dstwr_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic signed [31:0] round_time;
	logic signed [31:0] reply_time;
	logic [1:0]         session_stage;

	modport source (
		output valid, action, round_time, reply_time, session_stage,
		input  ready
	);
	modport sink (
		input  valid, action, round_time, reply_time, session_stage,
		output ready
	);
endinterface

// ===== rtl/dstwr_step.sv =====
// Step logic: next session state and result item for one radio event.
module dstwr_step #(
	parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
	input  logic [1:0]            command,
	input  logic [31:0]           now_ms,
	input  logic [7:0]            dest_id,
	input  logic [2:0]            frame_stage,
	input  logic                  is_error_frame,
	input  logic [STAMP_BITS-1:0] rx_stamp,
	input  logic [STAMP_BITS-1:0] tx_stamp,
	input  logic [7:0]            own_addr,
	input  logic [15:0]           timeout_ms,
	input  dstwr_pkg::sess_t      sess,
	input  logic [STAMP_BITS-1:0] saved_rx,
	input  logic [STAMP_BITS-1:0] saved_tx,
	output dstwr_pkg::upd_t       upd,
	output dstwr_pkg::result_t    result
);

	logic                  new_req;
	logic                  timed_out;
	logic [1:0]            cur_stage;
	logic [31:0]           idle_ms;
	logic [STAMP_BITS-1:0] reply_full;
	logic [STAMP_BITS-1:0] round_full;

	// A stage-1 request to this anchor restarts the session from idle
	assign new_req = (dstwr_pkg::cmd_t'(command) == dstwr_pkg::CMD_FRAME) &&
		(frame_stage == dstwr_pkg::FRAME_REQUEST) && (dest_id == own_addr);
	assign cur_stage = new_req ? dstwr_pkg::STG_IDLE : sess.stage;

	// Silence check, modulo 2^32
	assign idle_ms   = now_ms - sess.last_activity;
	assign timed_out = idle_ms > {16'd0, timeout_ms};

	// Stamp differences wrap in the stamp width; the low word is kept
	assign reply_full = tx_stamp - saved_rx;
	assign round_full = rx_stamp - saved_tx;

	always_comb begin
		upd                  = '0;
		upd.sess             = sess;
		result               = '0;
		result.action        = dstwr_pkg::ACT_NONE;
		case (cur_stage)
			dstwr_pkg::STG_WAIT_TX: begin
				if (dstwr_pkg::cmd_t'(command) == dstwr_pkg::CMD_TX_DONE) begin
					upd.ld_tx                 = 1'b1;
					upd.sess.reply_interval   = reply_full[31:0];
					upd.sess.stage            = dstwr_pkg::STG_WAIT_FN;
					upd.sess.last_activity    = now_ms;
				end
			end
			dstwr_pkg::STG_WAIT_FN: begin
				case (dstwr_pkg::cmd_t'(command))
					dstwr_pkg::CMD_POLL: begin
						if (timed_out) begin
							result.action          = dstwr_pkg::ACT_REARM;
							upd.sess.last_activity = now_ms;
						end
					end
					dstwr_pkg::CMD_FRAME: begin
						if (is_error_frame) begin
							result.action = dstwr_pkg::ACT_REARM;
						end else if (frame_stage != dstwr_pkg::FRAME_FINAL) begin
							result.action = dstwr_pkg::ACT_SEND_ERR;
						end else begin
							result.action     = dstwr_pkg::ACT_SEND_INFO;
							result.round_time = round_full[31:0];
							result.reply_time = sess.reply_interval;
						end
						upd.sess.stage = dstwr_pkg::STG_IDLE;
					end
					dstwr_pkg::CMD_RX_ERR: begin
						result.action = dstwr_pkg::ACT_CLR_ERR;
					end
					default: ;
				endcase
			end
			default: begin
				// Idle, and the unused stage code
				upd.sess.stage          = dstwr_pkg::STG_IDLE;
				upd.sess.reply_interval = '0;
				case (dstwr_pkg::cmd_t'(command))
					dstwr_pkg::CMD_POLL: begin
						if (timed_out) begin
							result.action          = dstwr_pkg::ACT_REARM;
							upd.sess.last_activity = now_ms;
						end
					end
					dstwr_pkg::CMD_FRAME: begin
						upd.sess.last_activity = now_ms;
						if ((dest_id != own_addr) || is_error_frame) begin
							result.action = dstwr_pkg::ACT_REARM;
						end else if (frame_stage != dstwr_pkg::FRAME_REQUEST) begin
							result.action = dstwr_pkg::ACT_SEND_ERR;
						end else begin
							upd.ld_rx      = 1'b1;
							upd.sess.stage = dstwr_pkg::STG_WAIT_TX;
							result.action  = dstwr_pkg::ACT_SEND_RESP;
						end
					end
					dstwr_pkg::CMD_RX_ERR: begin
						result.action = dstwr_pkg::ACT_CLR_ERR;
					end
					default: ;
				endcase
			end
		endcase
		result.session_stage = upd.sess.stage;
	end

endmodule

// ===== rtl/ds_twr_responder.sv =====
// Top level of the two-way ranging responder: registers, config and channels.
module ds_twr_responder #(
	parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dstwr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dstwr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	dstwr_evt_if.sink                        evt,
	dstwr_res_if.source                      res
);
	// One radio event item is taken per clock and its result item appears in
	// the output register on the next cycle, so the sustained rate is one item
	// per cycle. The session state is updated by a single pass of logic from
	// the accepted item and the state registers.
	// The event side stalls only while the output register holds a result
	// that the sink has not yet taken.

	logic                  evt_acc;
	logic [7:0]            own_addr_q;
	logic [15:0]           timeout_ms_q;
	dstwr_pkg::sess_t      sess_q;
	logic [STAMP_BITS-1:0] saved_rx_q;
	logic [STAMP_BITS-1:0] saved_tx_q;
	dstwr_pkg::upd_t       upd;
	dstwr_pkg::result_t    result;
	logic                  res_valid_q;
	dstwr_pkg::result_t    res_q;

	assign evt.ready = !res_valid_q || res.ready;
	assign evt_acc   = evt.valid && evt.ready;

	dstwr_step #(
		.STAMP_BITS (STAMP_BITS)
	) u_step (
		.command        (evt.command),
		.now_ms         (evt.now_ms),
		.dest_id        (evt.dest_id),
		.frame_stage    (evt.frame_stage),
		.is_error_frame (evt.is_error_frame),
		.rx_stamp       (evt.rx_stamp),
		.tx_stamp       (evt.tx_stamp),
		.own_addr       (own_addr_q),
		.timeout_ms     (timeout_ms_q),
		.sess           (sess_q),
		.saved_rx       (saved_rx_q),
		.saved_tx       (saved_tx_q),
		.upd            (upd),
		.result         (result)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q   <= dstwr_pkg::OWN_ADDR_RST;
			timeout_ms_q <= dstwr_pkg::TIMEOUT_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dstwr_pkg::REG_OWN_ADDR:   own_addr_q   <= cfg_wdata[7:0];
				dstwr_pkg::REG_TIMEOUT_MS: timeout_ms_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_q     <= '0;
			saved_rx_q <= '0;
			saved_tx_q <= '0;
		end else if (evt_acc) begin
			sess_q <= upd.sess;
			if (upd.ld_rx) begin
				saved_rx_q <= evt.rx_stamp;
			end
			if (upd.ld_tx) begin
				saved_tx_q <= evt.tx_stamp;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (evt_acc) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			res_q <= result;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.action        = res_q.action;
	assign res.round_time    = res_q.round_time;
	assign res.reply_time    = res_q.reply_time;
	assign res.session_stage = res_q.session_stage;

endmodule

// ===== rtl/dstwr_checker.sv =====
// Port-level checks of the ranging responder, bound to the top level.
`include "assert_macros.svh"

module dstwr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               evt_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [2:0]         action,
	input logic signed [31:0] round_time,
	input logic signed [31:0] reply_time,
	input logic [1:0]         session_stage
);

	// Held result does not change while the sink stalls
	`DSTWR_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(action) && $stable(round_time) && $stable(reply_time) && $stable(session_stage), "result changed under stall")

	// An empty output register never blocks the event side
	`DSTWR_ASSERT_ALWAYS(a_ready_empty, !res_valid |-> evt_ready, "event side stalled while empty")

	// Times are only reported with the info action
	`DSTWR_ASSERT(a_times_zero, res_valid && (action != dstwr_pkg::ACT_SEND_INFO) |-> (round_time == 0) && (reply_time == 0), "times set without info")

	// A response opens the session; info and error frames close it
	`DSTWR_ASSERT(a_resp_stage, res_valid && (action == dstwr_pkg::ACT_SEND_RESP) |-> session_stage == dstwr_pkg::STG_WAIT_TX, "response without open session")

	`DSTWR_ASSERT(a_close_stage, res_valid && ((action == dstwr_pkg::ACT_SEND_INFO) || (action == dstwr_pkg::ACT_SEND_ERR)) |-> session_stage == dstwr_pkg::STG_IDLE, "session left open")

endmodule

bind ds_twr_responder dstwr_checker u_dstwr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.evt_ready     (evt.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.action        (res.action),
	.round_time    (res.round_time),
	.reply_time    (res.reply_time),
	.session_stage (res.session_stage)
);

// ===== bench/ds_twr_responder_tb.sv =====
// Self-checking testbench for the ranging responder: random radio events against a predictor.
module ds_twr_responder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB = dstwr_pkg::STAMP_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [dstwr_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd2;

	// One radio event as the sender presents it
	typedef struct {
		dstwr_pkg::cmd_t command;
		logic [31:0]     now_ms;
		logic [7:0]      dest_id;
		logic [2:0]      frame_stage;
		logic            is_error_frame;
		logic [SB-1:0]   rx_stamp;
		logic [SB-1:0]   tx_stamp;
	} radio_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [dstwr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dstwr_pkg::CFG_DATA_W-1:0] cfg_wdata;

	dstwr_evt_if evt_ch ();
	dstwr_res_if res_ch ();

	ds_twr_responder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.evt       (evt_ch),
		.res       (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Register copies and session state of the predictor
	logic [7:0]    anchor_cfg = dstwr_pkg::OWN_ADDR_RST;
	logic [15:0]   timeout_cfg = dstwr_pkg::TIMEOUT_MS_RST;
	logic [1:0]    sess_stage = dstwr_pkg::STG_IDLE;
	logic [SB-1:0] stamp_rx = '0;
	logic [SB-1:0] stamp_tx = '0;
	logic [31:0]   reply_span = '0;
	logic [31:0]   last_heard = '0;

	radio_event_t         event_backlog[$];
	dstwr_pkg::result_t   due_responses[$];

	logic [31:0] clock_ms = '0;
	int          queued_count = 0;
	int          error_count = 0;
	int          cycle_count = 0;
	logic        evt_taken = 1'b0;
	logic        evt_busy = 1'b0;
	logic        steady_tail = 1'b0;
	logic        evt_steady = 1'b0;
	logic        res_steady = 1'b1;
	int          send_gap = 0;
	int          stall_gap = 0;

	// Timestamp difference modulo the stamp width, kept to 32 bits
	function automatic logic [31:0] wrap_span(logic [SB-1:0] a, logic [SB-1:0] b);
		logic [SB-1:0] d;
		d = a - b;
		return d[31:0];
	endfunction

	function automatic logic silence_expired(logic [31:0] now_ms);
		logic [31:0] quiet;
		quiet = now_ms - last_heard;
		return quiet > {16'd0, timeout_cfg};
	endfunction

	// Session step: updates the predicted state and returns the radio action due
	function automatic dstwr_pkg::result_t ranging_step(radio_event_t ev);
		dstwr_pkg::result_t r;
		r.action = dstwr_pkg::ACT_NONE;
		r.round_time = '0;
		r.reply_time = '0;
		// a fresh request to us aborts whatever session is open
		if (ev.command == dstwr_pkg::CMD_FRAME && ev.frame_stage == dstwr_pkg::FRAME_REQUEST &&
				ev.dest_id == anchor_cfg)
			sess_stage = dstwr_pkg::STG_IDLE;
		case (sess_stage)
			dstwr_pkg::STG_WAIT_TX: begin
				if (ev.command == dstwr_pkg::CMD_TX_DONE) begin
					stamp_tx = ev.tx_stamp;
					reply_span = wrap_span(ev.tx_stamp, stamp_rx);
					sess_stage = dstwr_pkg::STG_WAIT_FN;
					last_heard = ev.now_ms;
				end
			end
			dstwr_pkg::STG_WAIT_FN: begin
				case (ev.command)
					dstwr_pkg::CMD_POLL: begin
						if (silence_expired(ev.now_ms)) begin
							r.action = dstwr_pkg::ACT_REARM;
							last_heard = ev.now_ms;
						end
					end
					dstwr_pkg::CMD_FRAME: begin
						// address is not checked on the final frame
						if (ev.is_error_frame)
							r.action = dstwr_pkg::ACT_REARM;
						else if (ev.frame_stage != dstwr_pkg::FRAME_FINAL)
							r.action = dstwr_pkg::ACT_SEND_ERR;
						else begin
							r.action = dstwr_pkg::ACT_SEND_INFO;
							r.round_time = wrap_span(ev.rx_stamp, stamp_tx);
							r.reply_time = reply_span;
						end
						sess_stage = dstwr_pkg::STG_IDLE;
					end
					dstwr_pkg::CMD_RX_ERR: r.action = dstwr_pkg::ACT_CLR_ERR;
					default: ;
				endcase
			end
			default: begin
				// idle, and the unused stage code behaves the same
				sess_stage = dstwr_pkg::STG_IDLE;
				reply_span = '0;
				case (ev.command)
					dstwr_pkg::CMD_POLL: begin
						if (silence_expired(ev.now_ms)) begin
							r.action = dstwr_pkg::ACT_REARM;
							last_heard = ev.now_ms;
						end
					end
					dstwr_pkg::CMD_FRAME: begin
						last_heard = ev.now_ms;
						if (ev.dest_id != anchor_cfg || ev.is_error_frame)
							r.action = dstwr_pkg::ACT_REARM;
						else if (ev.frame_stage != dstwr_pkg::FRAME_REQUEST)
							r.action = dstwr_pkg::ACT_SEND_ERR;
						else begin
							stamp_rx = ev.rx_stamp;
							sess_stage = dstwr_pkg::STG_WAIT_TX;
							r.action = dstwr_pkg::ACT_SEND_RESP;
						end
					end
					dstwr_pkg::CMD_RX_ERR: r.action = dstwr_pkg::ACT_CLR_ERR;
					default: ;
				endcase
			end
		endcase
		r.session_stage = sess_stage;
		return r;
	endfunction

	task automatic note_mismatch(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("[%0t] %s", $realtime, msg);
	endtask

	// Event source: presents backlog items, with random gaps
	always @(negedge clk) begin
		radio_event_t nxt;
		if (arst_n) begin
			if ($urandom_range(0, 63) == 0)
				evt_steady = !evt_steady;
			if (!evt_busy || evt_taken) begin
				evt_busy = 1'b0;
				if (send_gap != 0)
					send_gap--;
				else if (event_backlog.size() != 0) begin
					if (!steady_tail && !evt_steady && $urandom_range(0, 4) == 0)
						send_gap = $urandom_range(1, 14) - 1;
					else begin
						nxt = event_backlog.pop_front();
						evt_ch.command <= nxt.command;
						evt_ch.now_ms <= nxt.now_ms;
						evt_ch.dest_id <= nxt.dest_id;
						evt_ch.frame_stage <= nxt.frame_stage;
						evt_ch.is_error_frame <= nxt.is_error_frame;
						evt_ch.rx_stamp <= nxt.rx_stamp;
						evt_ch.tx_stamp <= nxt.tx_stamp;
						evt_busy = 1'b1;
					end
				end
			end
			evt_ch.valid <= evt_busy;
		end
	end

	// Result sink: ready with random stall bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 63) == 0)
				res_steady = !res_steady;
			if (stall_gap != 0) begin
				stall_gap--;
				res_ch.ready <= 1'b0;
			end else if (!steady_tail && !res_steady && $urandom_range(0, 4) == 0) begin
				stall_gap = $urandom_range(1, 14) - 1;
				res_ch.ready <= 1'b0;
			end else
				res_ch.ready <= 1'b1;
		end
	end

	// Monitor: predict on accepted events, check accepted results
	always @(posedge clk) begin
		radio_event_t seen;
		dstwr_pkg::result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			evt_taken = arst_n && evt_ch.valid && evt_ch.ready;
			if (evt_taken) begin
				seen.command = dstwr_pkg::cmd_t'(evt_ch.command);
				seen.now_ms = evt_ch.now_ms;
				seen.dest_id = evt_ch.dest_id;
				seen.frame_stage = evt_ch.frame_stage;
				seen.is_error_frame = evt_ch.is_error_frame;
				seen.rx_stamp = evt_ch.rx_stamp;
				seen.tx_stamp = evt_ch.tx_stamp;
				due_responses.push_back(ranging_step(seen));
			end
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (due_responses.size() == 0)
					note_mismatch($sformatf("unexpected item: action %0d stage %0d",
						res_ch.action, res_ch.session_stage));
				else begin
					want = due_responses.pop_front();
					if (res_ch.action !== want.action ||
							res_ch.round_time !== want.round_time ||
							res_ch.reply_time !== want.reply_time ||
							res_ch.session_stage !== want.session_stage)
						note_mismatch($sformatf(
							"action %0d/%0d round %0d/%0d reply %0d/%0d stage %0d/%0d (exp/got)",
							want.action, res_ch.action, want.round_time, res_ch.round_time,
							want.reply_time, res_ch.reply_time,
							want.session_stage, res_ch.session_stage));
				end
			end
		end
	end

	task automatic queue_event(input dstwr_pkg::cmd_t c, input logic [31:0] now_ms,
			input logic [7:0] dest, input logic [2:0] fstage, input logic errf,
			input logic [SB-1:0] rx, input logic [SB-1:0] tx);
		radio_event_t ev;
		ev.command = c;
		ev.now_ms = now_ms;
		ev.dest_id = dest;
		ev.frame_stage = fstage;
		ev.is_error_frame = errf;
		ev.rx_stamp = rx;
		ev.tx_stamp = tx;
		event_backlog.push_back(ev);
		queued_count++;
	endtask

	// Wall clock: small steps, steps right at the timeout, and wild jumps
	function automatic logic [31:0] tick();
		case ($urandom_range(0, 9))
			0: clock_ms += $urandom;
			1: clock_ms += {16'd0, timeout_cfg} + $urandom_range(0, 2);
			default: clock_ms += $urandom_range(0, 6);
		endcase
		return clock_ms;
	endfunction

	function automatic logic [SB-1:0] rand_stamp();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0: w = '0;
			1: w = '1;
			default: ;
		endcase
		return w[SB-1:0];
	endfunction

	task automatic queue_noise();
		logic [7:0] dest;
		dest = $urandom_range(0, 1) ? anchor_cfg : 8'($urandom_range(0, 255));
		queue_event(dstwr_pkg::cmd_t'($urandom_range(0, 3)), tick(), dest,
			3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), rand_stamp(), rand_stamp());
	endtask

	// Mostly well-formed session: request, tx done, final frame, with noise between
	task automatic queue_session();
		logic [SB-1:0] rx;
		logic [SB-1:0] tx;
		logic [7:0]    dest;
		logic [2:0]    fstage;
		logic          errf;
		rx = rand_stamp();
		queue_event(dstwr_pkg::CMD_FRAME, tick(), anchor_cfg, dstwr_pkg::FRAME_REQUEST, 1'b0,
			rx, rand_stamp());
		repeat ($urandom_range(0, 2)) queue_noise();
		tx = $urandom_range(0, 3) == 0 ? rand_stamp() : rx + SB'($urandom_range(0, 1 << 20));
		queue_event(dstwr_pkg::CMD_TX_DONE, tick(), 8'($urandom_range(0, 255)),
			3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), rand_stamp(), tx);
		repeat ($urandom_range(0, 2)) queue_noise();
		dest = $urandom_range(0, 1) ? anchor_cfg : 8'($urandom_range(0, 255));
		errf = 1'b0;
		fstage = dstwr_pkg::FRAME_FINAL;
		case ($urandom_range(0, 9))
			0: begin
				errf = 1'b1;
				fstage = 3'($urandom_range(0, 7));
			end
			1: fstage = 3'($urandom_range(0, 7));
			default: ;
		endcase
		queue_event(dstwr_pkg::CMD_FRAME, tick(), dest, fstage, errf,
			tx + SB'($urandom_range(0, 1 << 22)), rand_stamp());
	endtask

	// Wait until nothing is in flight, then let the block settle
	task automatic drain();
		do
			@(posedge clk);
		while (event_backlog.size() != 0 || evt_ch.valid || due_responses.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic [dstwr_pkg::CFG_IDX_W-1:0] idx,
			input logic [dstwr_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dstwr_pkg::REG_OWN_ADDR: anchor_cfg = data[7:0];
			dstwr_pkg::REG_TIMEOUT_MS: timeout_cfg = data;
			default: ;
		endcase
	endtask

	task automatic run_phase(input logic [7:0] anchor, input logic [15:0] limit_ms,
			input int count);
		logic [7:0] junk;
		int stop_at;
		drain();
		junk = 8'($urandom_range(0, 255));
		write_register(dstwr_pkg::REG_OWN_ADDR, {junk, anchor});
		write_register(dstwr_pkg::REG_TIMEOUT_MS, limit_ms);
		stop_at = queued_count + count;
		while (queued_count < stop_at)
			if ($urandom_range(0, 3) != 0)
				queue_session();
			else
				queue_noise();
	endtask

	initial begin
		evt_ch.valid = 1'b0;
		evt_ch.command = dstwr_pkg::CMD_POLL;
		evt_ch.now_ms = '0;
		evt_ch.dest_id = '0;
		evt_ch.frame_stage = '0;
		evt_ch.is_error_frame = 1'b0;
		evt_ch.rx_stamp = '0;
		evt_ch.tx_stamp = '0;
		res_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dstwr_pkg::REG_OWN_ADDR;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: timeout edge and wrap, idle events, bad frames, full sessions
		queue_event(dstwr_pkg::CMD_POLL, 32'd10, 8'd0, 3'd0, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_POLL, 32'd11, 8'd0, 3'd0, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_POLL, 32'hFFFF_FFFF, 8'hFF, 3'd7, 1'b1, '1, '1);
		queue_event(dstwr_pkg::CMD_POLL, 32'd5, 8'd0, 3'd0, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_RX_ERR, 32'd5, 8'd3, 3'd1, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_TX_DONE, 32'd6, 8'd3, 3'd1, 1'b0, '0, '1);
		queue_event(dstwr_pkg::CMD_FRAME, 32'd7, 8'd4, dstwr_pkg::FRAME_REQUEST, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_FRAME, 32'd8, 8'd3, dstwr_pkg::FRAME_REQUEST, 1'b1, '0, '0);
		queue_event(dstwr_pkg::CMD_FRAME, 32'd9, 8'd3, 3'd7, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_FRAME, 32'd9, 8'd3, 3'd0, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_FRAME, 32'd10, 8'd3, dstwr_pkg::FRAME_REQUEST, 1'b0, '1, '0);
		queue_event(dstwr_pkg::CMD_POLL, 32'h8000_0000, 8'd0, 3'd0, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_RX_ERR, 32'd11, 8'd0, 3'd0, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_FRAME, 32'd12, 8'd3, dstwr_pkg::FRAME_FINAL, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_TX_DONE, 32'd13, 8'd0, 3'd0, 1'b0, '0, SB'(5));
		queue_event(dstwr_pkg::CMD_RX_ERR, 32'd14, 8'd0, 3'd0, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_FRAME, 32'd15, 8'hFF, dstwr_pkg::FRAME_FINAL, 1'b0,
			SB'(16), '0);
		queue_event(dstwr_pkg::CMD_FRAME, 32'd990, 8'd3, dstwr_pkg::FRAME_REQUEST, 1'b0,
			'0, '0);
		queue_event(dstwr_pkg::CMD_TX_DONE, 32'd1000, 8'd0, 3'd0, 1'b0, '0, '1);
		queue_event(dstwr_pkg::CMD_POLL, 32'd1011, 8'd0, 3'd0, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_FRAME, 32'd1012, 8'd3, dstwr_pkg::FRAME_REQUEST, 1'b0,
			SB'(40'h80_0000_0000), '0);
		queue_event(dstwr_pkg::CMD_TX_DONE, 32'd1013, 8'd0, 3'd0, 1'b0, '0,
			SB'(40'h80_7FFF_FFFF));
		queue_event(dstwr_pkg::CMD_FRAME, 32'd1014, 8'd3, 3'd2, 1'b0, '0, '0);
		queue_event(dstwr_pkg::CMD_FRAME, 32'd1015, 8'd3, dstwr_pkg::FRAME_REQUEST, 1'b0,
			'0, '0);
		queue_event(dstwr_pkg::CMD_TX_DONE, 32'd1016, 8'd0, 3'd0, 1'b0, '0, '1);
		queue_event(dstwr_pkg::CMD_FRAME, 32'd1017, 8'd3, dstwr_pkg::FRAME_FINAL, 1'b1,
			'0, '0);
		queue_event(dstwr_pkg::CMD_FRAME, 32'd1018, 8'd3, dstwr_pkg::FRAME_FINAL, 1'b0,
			'0, '0);
		clock_ms = 32'd1018;

		// Random phases across register settings, extremes included
		run_phase(dstwr_pkg::OWN_ADDR_RST, dstwr_pkg::TIMEOUT_MS_RST, 300);
		run_phase(8'd0, 16'd0, 300);
		run_phase(8'hFF, 16'hFFFF, 300);
		drain();
		write_register(REG_SPARE, '1);
		run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(0, 40)), 300);
		run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 300);
		steady_tail = 1'b1;
		run_phase(dstwr_pkg::OWN_ADDR_RST, dstwr_pkg::TIMEOUT_MS_RST, 400);
		drain();

		if (error_count == 0 && due_responses.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
